### src/bpa_pkg.sv
package bpa_pkg;

  localparam int TOP_ORDER    = 10;
  localparam int PAGE_W       = 16;
  localparam int ADDR_W       = PAGE_W + 1;
  localparam int LF_DEPTH     = 64;
  localparam int MAX_ORDER_IN = 16;

  localparam logic       CMD_ALLOC = 1'b0;
  localparam logic       CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_DFREE = 2'd3;

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_A_POP   = 15'b000000000000100,
    S_A_IDX   = 15'b000000000001000,
    S_A_CHK   = 15'b000000000010000,
    S_LARGE   = 15'b000000000100000,
    S_SPLIT   = 15'b000000001000000,
    S_ADD     = 15'b000000010000000,
    S_F_RD    = 15'b000000100000000,
    S_F_CHK0  = 15'b000001000000000,
    S_F_CHK1  = 15'b000010000000000,
    S_F_TOP   = 15'b000100000000000,
    S_F_CLR   = 15'b001000000000000,
    S_F_LARGE = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } bpa_state_t;

  // Address of entry i in an order's region of the shared bit and stack stores.
  function automatic logic [ADDR_W-1:0] lay_addr(logic [3:0] o, logic [PAGE_W-1:0] i);
    logic [ADDR_W:0] full;
    logic [ADDR_W:0] base;
    full = {1'b1, {ADDR_W{1'b0}}};
    base = full - (full >> o);
    return ADDR_W'(base) + {1'b0, i};
  endfunction

  function automatic logic [ADDR_W-1:0] lay_size(logic [3:0] o);
    return {1'b1, {PAGE_W{1'b0}}} >> o;
  endfunction

  function automatic logic [LF_DEPTH-1:0] run_mask(logic [7:0] lo, logic [7:0] hi);
    logic [LF_DEPTH-1:0] m;
    for (int k = 0; k < LF_DEPTH; k++) begin
      m[k] = (8'(k) >= lo) && (8'(k) < hi);
    end
    return m;
  endfunction

endpackage

### src/buddy_page_allocator.sv
// Channel   Direction  Signals
// in        input      in_valid, in_ready, in_cmd, in_order, in_page_number
// out       output     out_valid, out_ready, out_status, out_block_page
// cfg       input      cfg_wr_en, cfg_wr_data
//
// An allocation skips each empty order and pops stack entries, dropping any that are out of
// range; it scans up to 64 large frames when no order holds a block (or at once for order 10
// and up), then splits down to the order. A free walks the orders and clears merged buddies.
// After reset a clearing pass over all 131072 entries of the bit stores runs before in_ready rises.
// A finished result waits in the output register while the next transaction is taken.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [4:0]        in_order,
  input  logic [PAGE_W-1:0] in_page_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [PAGE_W-1:0] out_block_page,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data
);

  localparam int MEM_DEPTH = 1 << ADDR_W;

  logic              pres_mem [MEM_DEPTH];
  logic              stk_mem  [MEM_DEPTH];
  logic [PAGE_W-1:0] fs_mem   [MEM_DEPTH];

  bpa_state_t        state_r, state_nxt;
  logic              cmd_r, cmd_nxt;
  logic [4:0]        ord_r, ord_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [3:0]        cur_o_r, cur_o_nxt;
  logic [PAGE_W-1:0] idx_r, idx_nxt;
  logic [PAGE_W-1:0] addj_r, addj_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [PAGE_W-1:0] ci_r, ci_nxt;
  logic [6:0]        p_r, p_nxt;
  logic [6:0]        run_r, run_nxt;
  logic [6:0]        need_r, need_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] top_r [TOP_ORDER];
  logic [ADDR_W-1:0] top_nxt [TOP_ORDER];
  logic [LF_DEPTH-1:0] lfree_r, lfree_nxt;
  logic [6:0]        lfc_r, lfc_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [PAGE_W-1:0] res_blk_r, res_blk_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        os_r, os_nxt;
  logic [PAGE_W-1:0] ob_r, ob_nxt;

  logic              pres_q_r, stk_q_r;
  logic [PAGE_W-1:0] fs_q_r;

  logic [ADDR_W-1:0] pm_raddr, pm_waddr, fs_raddr, fs_waddr;
  logic              pm_we, pm_wd, sm_we, sm_wd, fs_we;
  logic [PAGE_W-1:0] fs_wd;

  logic [6:0]        lf_n;
  logic [6:0]        run_inc;
  logic [6:0]        start;
  logic [6:0]        lpos;
  logic [LF_DEPTH-1:0] fmask;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_block_page = ob_r;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pres_mem[pm_waddr] <= pm_wd;
    end
    if (sm_we) begin
      stk_mem[pm_waddr] <= sm_wd;
    end
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wd;
    end
    pres_q_r <= pres_mem[pm_raddr];
    stk_q_r  <= stk_mem[pm_raddr];
    fs_q_r   <= fs_mem[fs_raddr];
  end

  always_comb begin
    lf_n       = (lfc_r > 7'(LF_DEPTH)) ? 7'(LF_DEPTH) : lfc_r;
    run_inc    = lfree_r[p_r[5:0]] ? run_r + 7'd1 : 7'd0;
    start      = p_r + 7'd1 - need_r;
    lpos       = 7'(page_r >> TOP_ORDER);
    fmask      = run_mask({1'b0, lpos}, {1'b0, lpos} + {1'b0, need_r});

    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    ord_nxt     = ord_r;
    page_nxt    = page_r;
    cur_o_nxt   = cur_o_r;
    idx_nxt     = idx_r;
    addj_nxt    = addj_r;
    k_nxt       = k_r;
    ci_nxt      = ci_r;
    p_nxt       = p_r;
    run_nxt     = run_r;
    need_nxt    = need_r;
    clr_nxt     = clr_r;
    top_nxt     = top_r;
    lfree_nxt   = lfree_r;
    lfc_nxt     = cfg_wr_en ? cfg_wr_data : lfc_r;
    res_st_nxt  = res_st_r;
    res_blk_nxt = res_blk_r;
    ov_nxt      = ov_r;
    os_nxt      = os_r;
    ob_nxt      = ob_r;

    pm_raddr = '0;
    pm_waddr = '0;
    pm_we    = 1'b0;
    pm_wd    = 1'b0;
    sm_we    = 1'b0;
    sm_wd    = 1'b0;
    fs_raddr = '0;
    fs_waddr = '0;
    fs_we    = 1'b0;
    fs_wd    = '0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        pm_waddr = clr_r;
        pm_we    = 1'b1;
        sm_we    = 1'b1;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          ord_nxt     = in_order;
          page_nxt    = in_page_number;
          res_blk_nxt = '0;
          cur_o_nxt   = 4'(in_order);
          idx_nxt     = in_page_number >> in_order;
          need_nxt    = 7'(8'd1 << (in_order - 5'(TOP_ORDER)));
          p_nxt       = '0;
          run_nxt     = '0;
          if (in_order > 5'(MAX_ORDER_IN)) begin
            res_st_nxt = ST_BAD;
            state_nxt  = S_DONE;
          end else if (in_cmd == CMD_ALLOC) begin
            state_nxt = (in_order >= 5'(TOP_ORDER)) ? S_LARGE : S_A_POP;
          end else if ((in_page_number & ~(PAGE_W'(32'hFFFF_FFFF << in_order))) != '0) begin
            res_st_nxt = ST_BAD;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = (in_order >= 5'(TOP_ORDER)) ? S_F_LARGE : S_F_RD;
          end
        end
      end
      S_A_POP: begin
        if (cur_o_r == 4'(TOP_ORDER)) begin
          need_nxt  = 7'd1;
          p_nxt     = '0;
          run_nxt   = '0;
          state_nxt = S_LARGE;
        end else if (top_r[cur_o_r] == '0) begin
          cur_o_nxt = cur_o_r + 4'd1;
        end else begin
          top_nxt[cur_o_r] = top_r[cur_o_r] - 1'b1;
          fs_raddr  = lay_addr(cur_o_r, PAGE_W'(top_r[cur_o_r] - 1'b1));
          state_nxt = S_A_IDX;
        end
      end
      S_A_IDX: begin
        if ({1'b0, fs_q_r} >= lay_size(cur_o_r)) begin
          state_nxt = S_A_POP;
        end else begin
          idx_nxt   = fs_q_r;
          pm_raddr  = lay_addr(cur_o_r, fs_q_r);
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        pm_waddr  = lay_addr(cur_o_r, idx_r);
        pm_we     = 1'b1;
        sm_we     = 1'b1;
        state_nxt = pres_q_r ? S_SPLIT : S_A_POP;
      end
      S_LARGE: begin
        if (p_r >= lf_n) begin
          res_st_nxt = ST_OOM;
          state_nxt  = S_DONE;
        end else if (run_inc == need_r) begin
          lfree_nxt = lfree_r & ~run_mask({1'b0, start}, {1'b0, p_r} + 8'd1);
          if (ord_r >= 5'(TOP_ORDER)) begin
            res_st_nxt  = ST_OK;
            res_blk_nxt = PAGE_W'({25'd0, start} << TOP_ORDER);
            state_nxt   = S_DONE;
          end else begin
            idx_nxt   = PAGE_W'(start);
            cur_o_nxt = 4'(TOP_ORDER);
            state_nxt = S_SPLIT;
          end
        end else begin
          run_nxt = run_inc;
          p_nxt   = p_r + 7'd1;
        end
      end
      S_SPLIT: begin
        if ({1'b0, cur_o_r} > ord_r) begin
          idx_nxt   = idx_r << 1;
          addj_nxt  = (idx_r << 1) ^ PAGE_W'(1);
          cur_o_nxt = cur_o_r - 4'd1;
          pm_raddr  = lay_addr(cur_o_r - 4'd1, (idx_r << 1) ^ PAGE_W'(1));
          state_nxt = S_ADD;
        end else begin
          res_st_nxt  = ST_OK;
          res_blk_nxt = PAGE_W'({16'd0, idx_r} << ord_r);
          state_nxt   = S_DONE;
        end
      end
      S_ADD: begin
        pm_waddr = lay_addr(cur_o_r, addj_r);
        if (!pres_q_r) begin
          pm_we = 1'b1;
          pm_wd = 1'b1;
          if (!stk_q_r && (top_r[cur_o_r] < lay_size(cur_o_r))) begin
            sm_we    = 1'b1;
            sm_wd    = 1'b1;
            fs_we    = 1'b1;
            fs_waddr = lay_addr(cur_o_r, PAGE_W'(top_r[cur_o_r]));
            fs_wd    = addj_r;
            top_nxt[cur_o_r] = top_r[cur_o_r] + 1'b1;
          end
        end
        if (cmd_r == CMD_ALLOC) begin
          state_nxt = S_SPLIT;
        end else begin
          res_st_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_F_RD: begin
        pm_raddr  = lay_addr(cur_o_r, idx_r);
        state_nxt = S_F_CHK0;
      end
      S_F_CHK0: begin
        if (pres_q_r) begin
          res_st_nxt = ST_DFREE;
          state_nxt  = S_DONE;
        end else begin
          pm_raddr  = lay_addr(cur_o_r, idx_r ^ PAGE_W'(1));
          state_nxt = S_F_CHK1;
        end
      end
      S_F_CHK1: begin
        if (!pres_q_r || ((cur_o_r == 4'(TOP_ORDER - 1)) &&
                          ((idx_r >> 1) >= PAGE_W'(LF_DEPTH)))) begin
          state_nxt = S_F_TOP;
        end else begin
          idx_nxt   = idx_r >> 1;
          cur_o_nxt = cur_o_r + 4'd1;
          state_nxt = (cur_o_r == 4'(TOP_ORDER - 1)) ? S_F_TOP : S_F_RD;
        end
      end
      S_F_TOP: begin
        if ((cur_o_r == 4'(TOP_ORDER)) && lfree_r[idx_r[5:0]]) begin
          res_st_nxt = ST_DFREE;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = 4'(ord_r);
          ci_nxt    = page_r >> ord_r;
          state_nxt = S_F_CLR;
        end
      end
      S_F_CLR: begin
        if (k_r < cur_o_r) begin
          pm_waddr = lay_addr(k_r, ci_r ^ PAGE_W'(1));
          pm_we    = 1'b1;
          ci_nxt   = ci_r >> 1;
          k_nxt    = k_r + 4'd1;
        end else if (cur_o_r == 4'(TOP_ORDER)) begin
          lfree_nxt[idx_r[5:0]] = 1'b1;
          res_st_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          addj_nxt  = idx_r;
          pm_raddr  = lay_addr(cur_o_r, idx_r);
          state_nxt = S_ADD;
        end
      end
      S_F_LARGE: begin
        if (({1'b0, lpos} + {1'b0, need_r}) > 8'(LF_DEPTH)) begin
          res_st_nxt = ST_BAD;
        end else if ((fmask & lfree_r) != '0) begin
          res_st_nxt = ST_DFREE;
        end else begin
          lfree_nxt  = lfree_r | fmask;
          res_st_nxt = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          os_nxt    = res_st_r;
          ob_nxt    = (res_st_r == ST_OK) ? res_blk_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      lfree_r <= '0;
      lfc_r   <= 7'(LF_DEPTH);
      ov_r    <= 1'b0;
      for (int o = 0; o < TOP_ORDER; o++) begin
        top_r[o] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      lfree_r <= lfree_nxt;
      lfc_r   <= lfc_nxt;
      ov_r    <= ov_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    ord_r     <= ord_nxt;
    page_r    <= page_nxt;
    cur_o_r   <= cur_o_nxt;
    idx_r     <= idx_nxt;
    addj_r    <= addj_nxt;
    k_r       <= k_nxt;
    ci_r      <= ci_nxt;
    p_r       <= p_nxt;
    run_r     <= run_nxt;
    need_r    <= need_nxt;
    res_st_r  <= res_st_nxt;
    res_blk_r <= res_blk_nxt;
    os_r      <= os_nxt;
    ob_r      <= ob_nxt;
  end

endmodule

### bench/tb_buddy_page_allocator.sv
`timescale 1ns / 100ps

module tb_buddy_page_allocator import bpa_pkg::*; ();

  localparam int PAGES       = 65536;
  localparam int STORE       = 2 * PAGES;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic             cmd;
    logic [4:0]       order;
    logic [PAGE_W-1:0] page;
  } page_req_t;

  typedef struct {
    logic [1:0]        status;
    logic [PAGE_W-1:0] page;
  } page_resp_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_cmd;
  logic [4:0]        in_order;
  logic [PAGE_W-1:0] in_page_number;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [PAGE_W-1:0] out_block_page;
  logic              cfg_wr_en;
  logic [6:0]        cfg_wr_data;

  buddy_page_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_order       (in_order),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_block_page (out_block_page),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // Allocator shadow state.
  bit                present_q [STORE];
  bit                stacked_q [STORE];
  bit [ADDR_W-1:0]   stack_mem [STORE];
  int unsigned       stack_top [TOP_ORDER];
  int unsigned       order_base[TOP_ORDER];
  bit [LF_DEPTH-1:0] frame_free;
  int unsigned       frame_limit;

  page_req_t  pending_reqs[$];
  page_resp_t expected_resps[$];
  page_req_t  owned_blocks[$];

  int  sender_idle_pct;
  int  receiver_stall_pct;
  int  hold_off_cycles;
  int  mismatches;
  int  cycle_count;

  function automatic int unsigned order_size(int o);
    return PAGES >> o;
  endfunction

  function automatic bit order_has(int o, int unsigned i);
    if (o < TOP_ORDER && i < order_size(o)) return present_q[order_base[o] + i];
    return 0;
  endfunction

  function automatic void order_erase(int o, int unsigned i);
    if (o < TOP_ORDER && i < order_size(o)) present_q[order_base[o] + i] = 0;
  endfunction

  function automatic void order_insert(int o, int unsigned i);
    int unsigned b;
    if (!(o < TOP_ORDER && i < order_size(o))) return;
    b = order_base[o];
    if (present_q[b + i]) return;
    present_q[b + i] = 1;
    if (!stacked_q[b + i] && stack_top[o] < order_size(o)) begin
      stack_mem[b + stack_top[o]] = ADDR_W'(i);
      stack_top[o]++;
      stacked_q[b + i] = 1;
    end
  endfunction

  function automatic bit order_pop(int o, output int unsigned idx);
    int unsigned b;
    int unsigned i;
    b = order_base[o];
    idx = 0;
    while (stack_top[o] > 0) begin
      stack_top[o]--;
      i = stack_mem[b + stack_top[o]];
      if (i >= order_size(o)) continue;
      stacked_q[b + i] = 0;
      if (present_q[b + i]) begin
        present_q[b + i] = 0;
        idx = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit frames_claim(int unsigned need, output int unsigned pos);
    int unsigned n;
    int unsigned run;
    n = (frame_limit < LF_DEPTH) ? frame_limit : LF_DEPTH;
    run = 0;
    pos = 0;
    for (int unsigned p = 0; p < n; p++) begin
      run = frame_free[p] ? run + 1 : 0;
      if (run == need) begin
        pos = p + 1 - need;
        for (int unsigned k = pos; k <= p; k++) frame_free[k] = 0;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic logic [1:0] alloc_block(int order, output logic [PAGE_W-1:0] page);
    int unsigned idx;
    int o;
    bit found;
    page = '0;
    found = 0;
    if (order >= TOP_ORDER) begin
      if (!frames_claim(1 << (order - TOP_ORDER), idx)) return ST_OOM;
      page = PAGE_W'(idx << TOP_ORDER);
      return ST_OK;
    end
    for (o = order; o < TOP_ORDER; o++) begin
      if (order_pop(o, idx)) begin
        found = 1;
        break;
      end
    end
    if (!found) begin
      if (!frames_claim(1, idx)) return ST_OOM;
      o = TOP_ORDER;
    end
    for (; o > order; o--) begin
      idx = idx << 1;
      order_insert(o - 1, idx ^ 1);
    end
    page = PAGE_W'(idx << order);
    return ST_OK;
  endfunction

  function automatic logic [1:0] free_block(int order, int unsigned page);
    int unsigned idx;
    int unsigned i;
    int unsigned pos;
    int unsigned need;
    int o;
    if ((page & ((1 << order) - 1)) != 0) return ST_BAD;
    if (order >= TOP_ORDER) begin
      pos  = page >> TOP_ORDER;
      need = 1 << (order - TOP_ORDER);
      if (pos + need > LF_DEPTH) return ST_BAD;
      for (int unsigned k = pos; k < pos + need; k++) if (frame_free[k]) return ST_DFREE;
      for (int unsigned k = pos; k < pos + need; k++) frame_free[k] = 1;
      return ST_OK;
    end
    idx = page >> order;
    o = order;
    while (o < TOP_ORDER) begin
      if (order_has(o, idx)) return ST_DFREE;
      if (!order_has(o, idx ^ 1)) break;
      if (o + 1 == TOP_ORDER && (idx >> 1) >= LF_DEPTH) break;
      idx = idx >> 1;
      o++;
    end
    if (o == TOP_ORDER && frame_free[idx]) return ST_DFREE;
    i = page >> order;
    for (int k = order; k < o; k++) begin
      order_erase(k, i ^ 1);
      i = i >> 1;
    end
    if (o == TOP_ORDER) frame_free[idx] = 1;
    else order_insert(o, idx);
    return ST_OK;
  endfunction

  function automatic page_resp_t predict_alloc_result(page_req_t r);
    page_resp_t resp;
    resp.page = '0;
    if (r.order > MAX_ORDER_IN) resp.status = ST_BAD;
    else if (r.cmd == CMD_ALLOC) resp.status = alloc_block(r.order, resp.page);
    else resp.status = free_block(r.order, r.page);
    if (resp.status != ST_OK) resp.page = '0;
    return resp;
  endfunction

  task automatic send_req(logic cmd, int order, int unsigned page);
    page_req_t r;
    page_req_t blk;
    page_resp_t resp;
    r.cmd   = cmd;
    r.order = 5'(order);
    r.page  = PAGE_W'(page);
    resp = predict_alloc_result(r);
    pending_reqs.push_back(r);
    expected_resps.push_back(resp);
    if (cmd == CMD_ALLOC && resp.status == ST_OK) begin
      blk.cmd   = CMD_FREE;
      blk.order = r.order;
      blk.page  = resp.page;
      owned_blocks.push_back(blk);
    end
  endtask

  task automatic release_owned(bit twice);
    page_req_t blk;
    int k;
    k = $urandom_range(owned_blocks.size() - 1);
    blk = owned_blocks[k];
    owned_blocks.delete(k);
    send_req(CMD_FREE, blk.order, blk.page);
    if (twice) send_req(CMD_FREE, blk.order, blk.page);
  endtask

  task automatic send_random_req();
    int sel;
    int ord;
    int w;
    sel = $urandom_range(99);
    if (sel < 8) begin
      ord = $urandom_range(TOP_ORDER + 2, TOP_ORDER);
      send_req(CMD_FREE, ord,
               (($urandom_range(63) >> (ord - TOP_ORDER)) << (ord - TOP_ORDER)) << TOP_ORDER);
    end else if (sel < 48 || (sel < 85 && owned_blocks.size() == 0)) begin
      w = $urandom_range(99);
      if (w < 70) ord = $urandom_range(4);
      else if (w < 90) ord = $urandom_range(TOP_ORDER, 5);
      else ord = $urandom_range(MAX_ORDER_IN, TOP_ORDER + 1);
      send_req(CMD_ALLOC, ord, $urandom_range(65535));
    end else if (sel < 85) begin
      release_owned(0);
    end else if (sel < 92) begin
      ord = $urandom_range(MAX_ORDER_IN);
      if ($urandom_range(1)) send_req(CMD_FREE, ord, $urandom_range(65535));
      else send_req(CMD_FREE, ord, ($urandom_range(65535) >> ord) << ord);
    end else if (sel < 96 || owned_blocks.size() == 0) begin
      send_req(1'($urandom_range(1)), $urandom_range(31, MAX_ORDER_IN + 1),
               $urandom_range(65535));
    end else begin
      release_owned(1);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_frame_limit(int unsigned v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frame_limit = v;
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int unsigned limit, int count);
    write_frame_limit(limit);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_req();
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver: one transaction at a time from the pending queue.
  always @(posedge clk) begin
    page_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        r = pending_reqs.pop_front();
        in_cmd         <= r.cmd;
        in_order       <= r.order;
        in_page_number <= r.page;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    page_resp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d page %0h", out_status, out_block_page);
      end else begin
        e = expected_resps.pop_front();
        if (out_status !== e.status || out_block_page !== e.page) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d page %0h, got status %0d page %0h",
                     e.status, e.page, out_status, out_block_page);
        end
      end
    end
  end

  // Receiver: ready stays low for the whole hold-off stretch.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    int unsigned acc;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_cmd             = CMD_ALLOC;
    in_order           = '0;
    in_page_number     = '0;
    out_ready          = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_cycles    = 0;
    mismatches         = 0;
    cycle_count        = 0;
    acc = 0;
    for (int o = 0; o < TOP_ORDER; o++) begin
      order_base[o] = acc;
      acc += order_size(o);
      stack_top[o] = 0;
    end
    frame_free  = '0;
    frame_limit = 64;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_frame_limit(64);
    send_req(CMD_ALLOC, 0, 0);
    send_req(CMD_ALLOC, MAX_ORDER_IN, 0);
    send_req(CMD_ALLOC, MAX_ORDER_IN + 1, 0);
    send_req(CMD_FREE, 31, 16'hFFFF);
    send_req(CMD_FREE, 3, 5);
    send_req(CMD_FREE, 15, 16'h8000);
    send_req(CMD_FREE, 15, 16'h8000);
    send_req(CMD_FREE, MAX_ORDER_IN, 0);
    send_req(CMD_FREE, TOP_ORDER, 0);
    send_req(CMD_ALLOC, MAX_ORDER_IN, 0);
    send_req(CMD_ALLOC, 0, 16'hFFFF);
    send_req(CMD_ALLOC, 0, 0);
    send_req(CMD_FREE, 0, 0);
    send_req(CMD_FREE, 0, 0);
    send_req(CMD_FREE, 0, 1);
    send_req(CMD_FREE, 0, 16'hFFFF);
    send_req(CMD_ALLOC, TOP_ORDER - 1, 0);
    send_req(CMD_ALLOC, TOP_ORDER, 0);
    send_req(CMD_ALLOC, TOP_ORDER + 1, 0);
    send_req(CMD_FREE, TOP_ORDER + 2, 16'h1000);
    send_req(CMD_FREE, TOP_ORDER + 1, 16'h0800);
    send_req(CMD_ALLOC, 5, 0);
    send_req(CMD_FREE, 0, 16'h5555);
    send_req(CMD_FREE, 1, 16'hAAAA);
    drain();

    run_phase(0, 0, 64, 130);
    run_phase(63, 0, 0, 50);
    run_phase(0, 63, 127, 110);
    run_phase(25, 25, 3, 80);
    run_phase(25, 25, 64, 80);

    write_frame_limit(64);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_cycles    = 600;
    repeat (60) send_random_req();
    drain();

    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/bpa_pkg.sv
src/buddy_page_allocator.sv
bench/tb_buddy_page_allocator.sv
